// File: src/ipv4rx_pkg.sv
// ----------------------------------------------------------------------------
// ipv4rx_pkg
// Shared types and constants for the IPv4 receive header validator.
// ----------------------------------------------------------------------------
package ipv4rx_pkg;

	localparam logic [15:0] HDR_MIN = 16'd20;
	localparam logic [3:0]  IP_VERSION4 = 4'd4;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_RUNT      = 3'd1,
		ST_NOT_V4    = 3'd2,
		ST_BAD_IHL   = 3'd3,
		ST_TOTAL_BIG = 3'd4,
		ST_TOTAL_MIN = 3'd5,
		ST_CHECKSUM  = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0]  version_length;
		logic [15:0] total_length;
		logic [7:0]  protocol;
		logic [31:0] source;
		logic [31:0] destination;
		logic [16:0] sum;
		logic [7:0]  high_hold;
	} hdr_state_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  protocol;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [5:0]  header_bytes;
		logic [15:0] total_length;
		logic [15:0] payload_length;
	} result_t;

endpackage

// File: src/ipv4rx_byte_if.sv
// ----------------------------------------------------------------------------
// ipv4rx_byte_if
// Byte stream channel: one packet byte per transfer with a last flag.
// ----------------------------------------------------------------------------
interface ipv4rx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

// File: src/ipv4rx_result_if.sv
// ----------------------------------------------------------------------------
// ipv4rx_result_if
// Verdict channel: one header check result per transfer.
// ----------------------------------------------------------------------------
interface ipv4rx_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  protocol;
	logic [31:0] source_address;
	logic [31:0] destination_address;
	logic [5:0]  header_bytes;
	logic [15:0] total_length;
	logic [15:0] payload_length;

	modport source (
		output valid, output status, output protocol, output source_address,
		output destination_address, output header_bytes, output total_length,
		output payload_length, input ready
	);
	modport sink (
		input valid, input status, input protocol, input source_address,
		input destination_address, input header_bytes, input total_length,
		input payload_length, output ready
	);
endinterface

// File: src/ipv4rx_hdr_capture.sv
// ----------------------------------------------------------------------------
// ipv4rx_hdr_capture
// Byte counter, header field capture and ones-complement header sum.
// ----------------------------------------------------------------------------
module ipv4rx_hdr_capture #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               data_byte,
	input  logic                     last,
	output ipv4rx_pkg::hdr_state_t   nxt,
	output logic [COUNT_WIDTH-1:0]   count_nxt
);
	import ipv4rx_pkg::*;

	hdr_state_t             st_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [5:0]             hdr_len;
	logic [17:0]            word_sum;

	always_comb begin
		nxt = st_q;
		if (count_q == '0) begin
			nxt.version_length = data_byte;
		end
		hdr_len = {nxt.version_length[3:0], 2'b00};

		if (count_q == COUNT_WIDTH'(2)) begin
			nxt.total_length = {data_byte, st_q.total_length[7:0]};
		end else if (count_q == COUNT_WIDTH'(3)) begin
			nxt.total_length = {st_q.total_length[15:8], data_byte};
		end else if (count_q == COUNT_WIDTH'(9)) begin
			nxt.protocol = data_byte;
		end else if (count_q >= COUNT_WIDTH'(12) && count_q <= COUNT_WIDTH'(15)) begin
			nxt.source = {st_q.source[23:0], data_byte};
		end else if (count_q >= COUNT_WIDTH'(16) && count_q <= COUNT_WIDTH'(19)) begin
			nxt.destination = {st_q.destination[23:0], data_byte};
		end

		word_sum = {1'b0, st_q.sum} + {2'b00, st_q.high_hold, data_byte};
		if (count_q < COUNT_WIDTH'(hdr_len)) begin
			if (!count_q[0]) begin
				nxt.high_hold = data_byte;
			end else begin
				nxt.sum = {1'b0, word_sum[15:0]} + {15'd0, word_sum[17:16]};
			end
		end

		count_nxt = (count_q == '1) ? count_q : count_q + COUNT_WIDTH'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			count_q <= '0;
		end else if (step) begin
			if (last) begin
				st_q    <= '0;
				count_q <= '0;
			end else begin
				st_q    <= nxt;
				count_q <= count_nxt;
			end
		end
	end
endmodule

// File: src/ipv4rx_verdict.sv
// ----------------------------------------------------------------------------
// ipv4rx_verdict
// Ordered header checks and result formation on the final byte.
// ----------------------------------------------------------------------------
module ipv4rx_verdict #(
	parameter int COUNT_WIDTH = 16
) (
	input  ipv4rx_pkg::hdr_state_t hdr,
	input  logic [COUNT_WIDTH-1:0] len,
	output ipv4rx_pkg::result_t    res
);
	import ipv4rx_pkg::*;

	logic [5:0] hdr_len;
	status_t    status;

	always_comb begin
		hdr_len = {hdr.version_length[3:0], 2'b00};
		if (len < COUNT_WIDTH'(HDR_MIN)) begin
			status = ST_RUNT;
		end else if (hdr.version_length[7:4] != IP_VERSION4) begin
			status = ST_NOT_V4;
		end else if (hdr_len < HDR_MIN[5:0] || COUNT_WIDTH'(hdr_len) > len) begin
			status = ST_BAD_IHL;
		end else if (COUNT_WIDTH'(hdr.total_length) > len) begin
			status = ST_TOTAL_BIG;
		end else if (hdr.total_length < HDR_MIN) begin
			status = ST_TOTAL_MIN;
		end else if (hdr.sum[15:0] != 16'hffff) begin
			status = ST_CHECKSUM;
		end else begin
			status = ST_OK;
		end

		res.status              = status;
		res.protocol            = hdr.protocol;
		res.source_address      = hdr.source;
		res.destination_address = hdr.destination;
		res.header_bytes        = hdr_len;
		res.total_length        = hdr.total_length;
		if (status == ST_OK && hdr.total_length >= {10'd0, hdr_len}) begin
			res.payload_length = hdr.total_length - {10'd0, hdr_len};
		end else begin
			res.payload_length = '0;
		end
	end
endmodule

// File: src/ipv4_rx_header_validator.sv
// ----------------------------------------------------------------------------
// ipv4_rx_header_validator
// Pipeline: an input register feeds the capture/check logic and the result
// register. Throughput: one byte per cycle, except that a last byte stalls in
// the input register while the previous result is still unaccepted.
// Reset: arst_n clears all header state, counts and valid flags.
// ----------------------------------------------------------------------------
module ipv4_rx_header_validator #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	ipv4rx_byte_if.sink       pkt,
	ipv4rx_result_if.source   hdr
);
	import ipv4rx_pkg::*;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   advance;
	hdr_state_t             st_nxt;
	logic [COUNT_WIDTH-1:0] count_nxt;
	result_t                verdict;
	result_t                res_q;
	logic                   out_valid_q;

	assign advance   = valid_s1 && (!last_s1 || !out_valid_q || hdr.ready);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			byte_s1 <= pkt.data_byte;
			last_s1 <= pkt.last;
		end
	end

	ipv4rx_hdr_capture #(.COUNT_WIDTH(COUNT_WIDTH)) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last      (last_s1),
		.nxt       (st_nxt),
		.count_nxt (count_nxt)
	);

	ipv4rx_verdict #(.COUNT_WIDTH(COUNT_WIDTH)) u_verdict (
		.hdr (st_nxt),
		.len (count_nxt),
		.res (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (hdr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= verdict;
		end
	end

	assign hdr.valid               = out_valid_q;
	assign hdr.status              = res_q.status;
	assign hdr.protocol            = res_q.protocol;
	assign hdr.source_address      = res_q.source_address;
	assign hdr.destination_address = res_q.destination_address;
	assign hdr.header_bytes        = res_q.header_bytes;
	assign hdr.total_length        = res_q.total_length;
	assign hdr.payload_length      = res_q.payload_length;
endmodule

// File: tb/sv/ipv4_rx_header_validator_tb.sv
// ----------------------------------------------------------------------------
// ipv4_rx_header_validator_tb
// Feeds byte streams of IPv4 packets (well-formed, broken, runts and noise)
// into the validator and checks every verdict against a scoreboard that
// tracks header capture and checksum byte by byte. Both channels idle and
// stall at random over several phases.
// ----------------------------------------------------------------------------
module ipv4_rx_header_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipv4rx_pkg::*;

	localparam int COUNT_WIDTH = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_BYTES = 170;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	class verdict_board;
		logic [COUNT_WIDTH-1:0] count;
		logic [7:0]  ver_ihl;
		logic [15:0] total;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [16:0] csum;
		logic [7:0]  hi_hold;
		result_t     expected_verdicts[$];
		int          errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			count = '0;
			ver_ihl = '0;
			total = '0;
			proto = '0;
			src = '0;
			dst = '0;
			csum = '0;
			hi_hold = '0;
		endfunction

		// Note one accepted byte; a last byte queues the verdict.
		function void take_byte(logic [7:0] b, logic is_last);
			int unsigned idx;
			int unsigned hdr_len;
			int unsigned buf_len;
			logic [17:0] word_sum;
			result_t v;
			idx = count;
			if (idx == 0)
				ver_ihl = b;
			hdr_len = int'(ver_ihl[3:0]) * 4;
			if (idx == 2)
				total[15:8] = b;
			else if (idx == 3)
				total[7:0] = b;
			else if (idx == 9)
				proto = b;
			else if (idx >= 12 && idx <= 15)
				src = {src[23:0], b};
			else if (idx >= 16 && idx <= 19)
				dst = {dst[23:0], b};
			if (idx < hdr_len) begin
				if (idx % 2 == 0) begin
					hi_hold = b;
				end else begin
					word_sum = {1'b0, csum} + {2'd0, hi_hold, b};
					csum = {1'b0, word_sum[15:0]} + {15'd0, word_sum[17:16]};
				end
			end
			if (count != '1)
				count++;
			if (!is_last)
				return;
			buf_len = count;
			if (buf_len < HDR_MIN)
				v.status = ST_RUNT;
			else if (ver_ihl[7:4] != IP_VERSION4)
				v.status = ST_NOT_V4;
			else if (hdr_len < HDR_MIN || hdr_len > buf_len)
				v.status = ST_BAD_IHL;
			else if (total > buf_len)
				v.status = ST_TOTAL_BIG;
			else if (total < HDR_MIN)
				v.status = ST_TOTAL_MIN;
			else if (csum[15:0] != 16'hffff)
				v.status = ST_CHECKSUM;
			else
				v.status = ST_OK;
			v.protocol = proto;
			v.source_address = src;
			v.destination_address = dst;
			v.header_bytes = 6'(hdr_len);
			v.total_length = total;
			if (v.status == ST_OK && total >= hdr_len)
				v.payload_length = 16'(total - hdr_len);
			else
				v.payload_length = 16'd0;
			expected_verdicts.push_back(v);
			clear();
		endfunction

		function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
			if (act_val !== exp_val) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h",
					$time, name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void compare_verdict(result_t seen);
			result_t want;
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected verdict: expected none, actual status %0d",
					$time, seen.status);
				errors++;
				return;
			end
			want = expected_verdicts.pop_front();
			check_field("status", 32'(want.status), 32'(seen.status));
			check_field("protocol", 32'(want.protocol), 32'(seen.protocol));
			check_field("source_address", want.source_address, seen.source_address);
			check_field("destination_address", want.destination_address,
				seen.destination_address);
			check_field("header_bytes", 32'(want.header_bytes), 32'(seen.header_bytes));
			check_field("total_length", 32'(want.total_length), 32'(seen.total_length));
			check_field("payload_length", 32'(want.payload_length),
				32'(seen.payload_length));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ipv4rx_byte_if   pkt_if ();
	ipv4rx_result_if hdr_if ();

	ipv4_rx_header_validator #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.pkt   (pkt_if),
		.hdr   (hdr_if)
	);

	verdict_board board = new();

	logic [7:0] frame_bytes[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;

	always #10 clk = ~clk;

	// result side: check transfers, pick ready for the next cycle
	initial begin
		int hold_left;
		int hold_served;
		result_t seen;
		hold_left = 0;
		hold_served = 0;
		hdr_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && hdr_if.valid && hdr_if.ready) begin
				seen.status = status_t'(hdr_if.status);
				seen.protocol = hdr_if.protocol;
				seen.source_address = hdr_if.source_address;
				seen.destination_address = hdr_if.destination_address;
				seen.header_bytes = hdr_if.header_bytes;
				seen.total_length = hdr_if.total_length;
				seen.payload_length = hdr_if.payload_length;
				board.compare_verdict(seen);
			end
			if (hold_left > 0) begin
				hold_left--;
				hdr_if.ready <= 1'b0;
			end else if (hold_req != hold_served) begin
				hold_served = hold_req;
				hold_left = LONG_HOLD;
				hdr_if.ready <= 1'b0;
			end else begin
				hdr_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((pkt_if.valid && pkt_if.ready) || (hdr_if.valid && hdr_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("ipv4_rx_header_validator_tb failed");
			$finish;
		end
	end

	task automatic make_packet(int ver, int ihl, int ip_len, int buf_len, fill_t fill,
			bit fix_sum);
		int hdr_len;
		int unsigned acc;
		logic [15:0] w;
		frame_bytes.delete();
		for (int i = 0; i < buf_len; i++) begin
			case (fill)
				FILL_ZERO: frame_bytes.push_back(8'h00);
				FILL_ONES: frame_bytes.push_back(8'hff);
				default:   frame_bytes.push_back(8'($urandom));
			endcase
		end
		frame_bytes[0] = {4'(ver), 4'(ihl)};
		if (buf_len > 3) begin
			frame_bytes[2] = ip_len[15:8];
			frame_bytes[3] = ip_len[7:0];
		end
		hdr_len = ihl * 4;
		if (fix_sum && hdr_len >= HDR_MIN && buf_len >= hdr_len) begin
			frame_bytes[10] = 8'h00;
			frame_bytes[11] = 8'h00;
			acc = 0;
			for (int i = 0; i < hdr_len; i += 2) begin
				acc += {frame_bytes[i], frame_bytes[i+1]};
				acc = (acc & 32'hffff) + (acc >> 16);
			end
			w = ~16'(acc);
			frame_bytes[10] = w[15:8];
			frame_bytes[11] = w[7:0];
		end
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++) begin
			if ($urandom_range(0, 99) < send_idle_pct) begin
				pkt_if.valid <= 1'b0;
				do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
			end
			pkt_if.valid <= 1'b1;
			pkt_if.data_byte <= frame_bytes[i];
			pkt_if.last <= (i == frame_bytes.size() - 1);
			do @(posedge clk); while (!pkt_if.ready);
			board.take_byte(frame_bytes[i], i == frame_bytes.size() - 1);
			bytes_sent++;
		end
	endtask

	task automatic drain_results();
		pkt_if.valid <= 1'b0;
		do @(posedge clk); while (board.expected_verdicts.size() != 0);
	endtask

	task automatic random_packet();
		int kind;
		int ihl;
		int hdr_len;
		int ip_len;
		int buf_len;
		kind = $urandom_range(0, 9);
		ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
		hdr_len = ihl * 4;
		ip_len = hdr_len + $urandom_range(0, 12);
		if ($urandom_range(0, 7) == 0)
			ip_len = $urandom_range(20, hdr_len);
		buf_len = (ip_len > hdr_len) ? ip_len : hdr_len;
		if ($urandom_range(0, 3) == 0)
			buf_len += $urandom_range(1, 6);
		case (kind)
			6: make_packet(IP_VERSION4, 5, $urandom_range(0, 65535), $urandom_range(1, 19),
				FILL_RANDOM, 0);
			7: begin
				make_packet(IP_VERSION4, ihl, ip_len, buf_len, FILL_RANDOM, 1);
				case ($urandom_range(0, 5))
					0: frame_bytes[0][7:4] = 4'(IP_VERSION4 + $urandom_range(1, 15));
					1: frame_bytes[0][3:0] = 4'($urandom_range(0, 4));
					2: make_packet(IP_VERSION4, 15, 40, $urandom_range(20, 59), FILL_RANDOM, 1);
					3: begin
						ip_len = buf_len + $urandom_range(1, 1000);
						frame_bytes[2] = ip_len[15:8];
						frame_bytes[3] = ip_len[7:0];
					end
					4: begin
						frame_bytes[2] = 8'h00;
						frame_bytes[3] = 8'($urandom_range(0, 19));
					end
					default: begin
						int pos;
						pos = $urandom_range(4, hdr_len - 1);
						frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
					end
				endcase
			end
			8: make_packet($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 65535),
				$urandom_range(20, 48), FILL_RANDOM, 0);
			default: make_packet(IP_VERSION4, ihl, ip_len, buf_len, FILL_RANDOM, 1);
		endcase
		send_frame();
	endtask

	initial begin
		int phase;
		pkt_if.valid = 1'b0;
		pkt_if.data_byte = 8'h00;
		pkt_if.last = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed packets, no idling
		make_packet(IP_VERSION4, 5, 20, 20, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 5, 20, 1, FILL_RANDOM, 0);
		send_frame();
		make_packet(IP_VERSION4, 5, 20, 19, FILL_RANDOM, 0);
		send_frame();
		make_packet(0, 0, 0, 20, FILL_ZERO, 0);
		send_frame();
		make_packet(15, 15, 65535, 60, FILL_ONES, 0);
		send_frame();
		make_packet(5, 5, 20, 20, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 15, 60, 60, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 15, 40, 60, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 15, 60, 40, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 4, 20, 20, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 0, 20, 20, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 5, 21, 20, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 5, 65535, 20, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 5, 19, 20, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 5, 0, 20, FILL_RANDOM, 1);
		send_frame();
		make_packet(IP_VERSION4, 5, 20, 20, FILL_RANDOM, 1);
		frame_bytes[12] = frame_bytes[12] ^ 8'h10;
		send_frame();
		make_packet(IP_VERSION4, 5, 30, 45, FILL_RANDOM, 1);
		send_frame();
		drain_results();

		// long receiver hold while short packets keep coming
		hold_req++;
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 2)
				make_packet(IP_VERSION4, 5, 20, 20, FILL_RANDOM, 1);
			else
				make_packet(IP_VERSION4, 5, 20, $urandom_range(1, 4), FILL_RANDOM, 0);
			send_frame();
		end
		drain_results();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 85;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 85;
				end
				default: begin
					send_idle_pct = 28;
					recv_stall_pct = 28;
				end
			endcase
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES)
				random_packet();
			drain_results();
		end

		repeat (4) @(posedge clk);
		if (board.errors == 0 && board.expected_verdicts.size() == 0)
			$display("ipv4_rx_header_validator_tb passed");
		else
			$display("ipv4_rx_header_validator_tb failed");
		$finish;
	end

endmodule
